// ===== hw/rtl/sfr_pkg.sv =====
// shared types and constants of the serial frame receiver
`default_nettype none

package sfr_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 4'd1;

	localparam logic [15:0] HEADER_RESET = 16'h55AA;
	localparam logic [5:0] MAX_LENGTH_RESET = 6'd32;
	localparam int LIMIT_CAP = 32;

	localparam logic [1:0] STATUS_GOOD = 2'd0;
	localparam logic [1:0] STATUS_CSUM = 2'd1;
	localparam logic [1:0] STATUS_LEN = 2'd2;

	// one finished frame handed from the parser to the result side
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] ext;
		logic [7:0] ftype;
		logic [5:0] flen;
		logic [5:0] count;
		logic       bank;
	} desc_t;

	typedef struct packed {
		logic       valid;
		logic       bank;
	} release_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] ext;
		logic [7:0] ftype;
		logic [5:0] flen;
		logic       has_data;
		logic [7:0] data;
		logic [4:0] idx;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_front.sv =====
// frame parser: header hunt, field capture, checksum and payload buffering
`default_nettype none

module sfr_front import sfr_pkg::*; #(
	parameter int CAP = 32,
	parameter int AW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output      logic          full,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [15:0]   header_word,
	input  wire logic [5:0]    max_length,
	input  wire logic          q_full,
	output      logic          q_push,
	output      desc_t         q_data,
	output      logic          wr_en,
	output      logic [AW:0]   wr_addr,
	output      logic [7:0]    wr_data,
	input  wire release_t      rel
);

	typedef enum logic [7:0] {
		PH_HUNT_HI = 8'b0000_0001,
		PH_HUNT_LO = 8'b0000_0010,
		PH_EXT     = 8'b0000_0100,
		PH_TYPE    = 8'b0000_1000,
		PH_LEN_HI  = 8'b0001_0000,
		PH_LEN_LO  = 8'b0010_0000,
		PH_PAYLOAD = 8'b0100_0000,
		PH_CHECK   = 8'b1000_0000
	} phase_t;

	localparam logic [5:0] CapW = 6'(CAP);

	phase_t      phase_q, phase_d;
	logic [7:0]  ext_q;
	logic [7:0]  type_q;
	logic [15:0] len_q;
	logic [5:0]  cnt_q;
	logic [7:0]  sum_q;
	logic        bank_q;
	logic [1:0]  busy_q;

	logic        accept;
	logic [5:0]  lim;
	logic [15:0] len_full;
	logic [7:0]  sum_next;
	logic [5:0]  cnt_next;
	logic [7:0]  hdr_hi;
	logic [7:0]  hdr_lo;
	logic        good_data;

	assign hdr_hi   = header_word[15:8];
	assign hdr_lo   = header_word[7:0];
	assign lim      = (max_length > CapW) ? CapW : max_length;
	assign len_full = {len_q[15:8], rx_byte};
	assign sum_next = sum_q + rx_byte;
	assign cnt_next = cnt_q + 6'd1;

	assign full = ((phase_q == PH_PAYLOAD) && busy_q[bank_q]) ||
		(((phase_q == PH_LEN_LO) || (phase_q == PH_CHECK)) && q_full);
	assign accept = push && !full;

	assign wr_en   = accept && (phase_q == PH_PAYLOAD);
	assign wr_addr = {bank_q, cnt_q[AW-1:0]};
	assign wr_data = rx_byte;

	assign good_data = accept && (phase_q == PH_CHECK) && (rx_byte == sum_q) &&
		(len_q != 16'd0);

	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		q_data.ext = ext_q;
		q_data.ftype = type_q;
		q_data.bank = bank_q;
		q_data.flen = (len_q > {10'd0, lim}) ? lim : len_q[5:0];
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT_HI: begin
				if (rx_byte == hdr_hi) phase_d = PH_HUNT_LO;
			end
			PH_HUNT_LO: begin
				if (rx_byte == hdr_lo) phase_d = PH_EXT;
				else if (rx_byte != hdr_hi) phase_d = PH_HUNT_HI;
			end
			PH_EXT:    phase_d = PH_TYPE;
			PH_TYPE:   phase_d = PH_LEN_HI;
			PH_LEN_HI: phase_d = PH_LEN_LO;
			PH_LEN_LO: begin
				if (len_full > {10'd0, lim}) begin
					q_push = accept;
					q_data.status = STATUS_LEN;
					q_data.flen = lim;
					phase_d = PH_HUNT_HI;
				end else if (len_full == 16'd0) begin
					phase_d = PH_CHECK;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if ({10'd0, cnt_next} >= len_q) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				q_push = accept;
				if (rx_byte != sum_q) begin
					q_data.status = STATUS_CSUM;
				end else begin
					q_data.status = STATUS_GOOD;
					q_data.count = len_q[5:0];
				end
				phase_d = PH_HUNT_HI;
			end
			default: phase_d = PH_HUNT_HI;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_HI;
			ext_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			unique case (phase_q)
				PH_HUNT_LO: begin
					if (rx_byte == hdr_lo) sum_q <= hdr_hi + hdr_lo;
				end
				PH_EXT: begin
					ext_q <= rx_byte;
					sum_q <= sum_next;
				end
				PH_TYPE: begin
					type_q <= rx_byte;
					sum_q  <= sum_next;
				end
				PH_LEN_HI: begin
					len_q <= {rx_byte, 8'd0};
					sum_q <= sum_next;
				end
				PH_LEN_LO: begin
					len_q <= len_full;
					sum_q <= sum_next;
					cnt_q <= '0;
				end
				PH_PAYLOAD: begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
				PH_CHECK: begin
					if (good_data) bank_q <= ~bank_q;
				end
				default: ;
			endcase
		end
	end

	// a bank stays reserved until the result side has read its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (good_data) busy_q[bank_q] <= 1'b1;
			if (rel.valid) busy_q[rel.bank] <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_fifo.sv =====
// two-entry queue of frame descriptors between parser and result side
`default_nettype none

module sfr_fifo import sfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire desc_t wdata,
	output      logic  q_full,
	input  wire logic  rd,
	output      desc_t rdata,
	output      logic  q_empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW:0] DepthW = (PW + 1)'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LastPtr = PW'(QUEUE_DEPTH - 1);

	desc_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (cnt_q == DepthW);
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_back.sv =====
// result side: expands each frame descriptor into result requests
`default_nettype none

module sfr_back import sfr_pkg::*; #(
	parameter int AW = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire desc_t       q_data,
	output      logic        q_pop,
	output      logic        rd_en,
	output      logic [AW:0] rd_addr,
	input  wire logic [7:0]  rd_data,
	output      release_t    rel,
	input  wire logic        pop,
	output      logic        empty,
	output      result_t     res
);

	logic    active_q;
	desc_t   cur_q;
	logic [4:0] idx_q;
	logic    valid_s1;
	result_t res_s1;
	logic    out_valid_q;
	result_t out_q;

	logic adv;
	logic issue;
	logic data_mode;
	logic last_issue;

	assign data_mode  = (cur_q.count != 6'd0);
	assign last_issue = !data_mode || (({1'b0, idx_q} + 6'd1) == cur_q.count);
	assign adv        = valid_s1 && (!out_valid_q || pop);
	assign issue      = active_q && (!valid_s1 || adv);
	assign q_pop      = !active_q && !q_empty;

	assign rd_en    = issue && data_mode;
	assign rd_addr  = {cur_q.bank, idx_q[AW-1:0]};
	assign rel.valid = issue && data_mode && last_issue;
	assign rel.bank  = cur_q.bank;

	assign empty = !out_valid_q;
	assign res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) active_q <= 1'b1;
			else if (issue && last_issue) active_q <= 1'b0;

			if (issue) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;

			if (adv) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
			idx_q <= '0;
		end else if (issue && !last_issue) begin
			idx_q <= idx_q + 5'd1;
		end
		if (issue) begin
			res_s1.status   <= cur_q.status;
			res_s1.ext      <= cur_q.ext;
			res_s1.ftype    <= cur_q.ftype;
			res_s1.flen     <= cur_q.flen;
			res_s1.has_data <= data_mode;
			res_s1.data     <= '0;
			res_s1.idx      <= data_mode ? idx_q : 5'd0;
			res_s1.last     <= last_issue;
		end
		if (adv) begin
			out_q.status   <= res_s1.status;
			out_q.ext      <= res_s1.ext;
			out_q.ftype    <= res_s1.ftype;
			out_q.flen     <= res_s1.flen;
			out_q.has_data <= res_s1.has_data;
			// payload byte arrives from the ram in the cycle after the read
			out_q.data     <= res_s1.has_data ? rd_data : 8'd0;
			out_q.idx      <= res_s1.idx;
			out_q.last     <= res_s1.last;
		end
	end

	a_nodata_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_data |-> out_q.last)
		else $error("result without data is not the last of its run");

	a_release_active: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> active_q && data_mode)
		else $error("bank released with no data frame in progress");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.has_data && !adv |=> $stable(rd_data))
		else $error("ram read data changed while its request was stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_receiver_unit.sv =====
// Serial frame receiver. Takes one received byte per clock on push/full, hunts for the
// two-byte header, captures extension, type and big-endian length, buffers the payload
// and checks the 8-bit sum. The parser accepts a byte every cycle; full rises only at
// the low length byte or the checksum byte while the two-entry frame queue is full, or at a payload
// byte while the payload bank it fills is still being read out. Two payload banks, each
// holding up to min(MAX_PAYLOAD, 32) bytes, let one frame be received while the previous one drains.
// A finished frame gives its results at one per clock as pop allows, through a request
// register and an output register: one per payload byte for a good frame with payload,
// otherwise a single result. No clearing pass is needed after reset. Configuration writes are always
// taken (cfg_ready is tied high); register 0 is header_word, register 1 max_length.
`default_nettype none

module serial_frame_receiver_unit import sfr_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output      logic                 full,
	input  wire logic [7:0]           rx_byte,
	output      logic                 empty,
	input  wire logic                 pop,
	output      logic [1:0]           status,
	output      logic [7:0]           frame_ext,
	output      logic [7:0]           frame_type,
	output      logic [5:0]           frame_length,
	output      logic                 has_data,
	output      logic [7:0]           data_byte,
	output      logic [4:0]           byte_index,
	output      logic                 last,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	localparam int Cap = (MAX_PAYLOAD < LIMIT_CAP) ? MAX_PAYLOAD : LIMIT_CAP;
	localparam int Aw = (Cap > 1) ? $clog2(Cap) : 1;
	localparam int RamDepth = 2 * (2 ** Aw);

	logic [15:0] header_q;
	logic [5:0]  maxlen_q;

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	desc_t       q_wdata;
	desc_t       q_rdata;
	logic        wr_en;
	logic [Aw:0] wr_addr;
	logic [7:0]  wr_data;
	logic        rd_en;
	logic [Aw:0] rd_addr;
	logic [7:0]  rd_data;
	release_t    rel;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			maxlen_q <= MAX_LENGTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HEADER_WORD: header_q <= cfg_data;
				CFG_MAX_LENGTH:  maxlen_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	sfr_front #(.CAP(Cap), .AW(Aw)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.header_word (header_q),
		.max_length  (maxlen_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rel         (rel)
	);

	sfr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wdata   (q_wdata),
		.q_full  (q_full),
		.rd      (q_pop),
		.rdata   (q_rdata),
		.q_empty (q_empty)
	);

	sfr_ram #(.WIDTH(8), .DEPTH(RamDepth)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sfr_back #(.AW(Aw)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rel     (rel),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign status       = res.status;
	assign frame_ext    = res.ext;
	assign frame_type   = res.ftype;
	assign frame_length = res.flen;
	assign has_data     = res.has_data;
	assign data_byte    = res.data;
	assign byte_index   = res.idx;
	assign last         = res.last;

endmodule

`default_nettype wire

// ===== tb/serial_frame_receiver_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench of the serial frame receiver unit: directed and random frames against a predictor
module serial_frame_receiver_unit_tb;
	import sfr_pkg::*;

	localparam int PAYLOAD_MAX = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 4'd15;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_BYTES = 180;
	localparam int WHOLE_FRAME = 64;

	typedef enum logic [2:0] {
		SEEK_HI, SEEK_LO, GET_EXT, GET_TYPE, GET_LEN_HI, GET_LEN_LO, GET_PAYLOAD, GET_CSUM
	} parse_phase_e;

	logic clk = 1'b0;
	logic arst_n;
	logic push, full, empty, pop;
	logic [7:0] rx_byte;
	logic [1:0] status;
	logic [7:0] frame_ext, frame_type, data_byte;
	logic [5:0] frame_length;
	logic has_data, last;
	logic [4:0] byte_index;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	// predictor state
	logic [15:0] hdr_word;
	logic [5:0] max_len_reg;
	parse_phase_e rx_phase;
	logic [7:0] ext_q, type_q, sum_q;
	logic [15:0] len_q;
	logic [5:0] count_q;
	logic [7:0] payload_mem [PAYLOAD_MAX];

	result_t pending_frame_results[$];
	logic [7:0] frame_bytes[$];
	logic [7:0] payload_buf [PAYLOAD_MAX];
	int errors = 0;
	int frame_bytes_sent = 0;
	bit gaps_on = 1'b0;
	bit stall_on = 1'b0;

	serial_frame_receiver_unit #(.MAX_PAYLOAD(PAYLOAD_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop),
		.status(status), .frame_ext(frame_ext), .frame_type(frame_type),
		.frame_length(frame_length), .has_data(has_data), .data_byte(data_byte),
		.byte_index(byte_index), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int length_limit();
		int lim;
		lim = max_len_reg;
		if (lim > PAYLOAD_MAX) lim = PAYLOAD_MAX;
		if (lim > LIMIT_CAP) lim = LIMIT_CAP;
		return lim;
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf("st=%0d ext=%02h type=%02h len=%0d data=%0b/%02h idx=%0d last=%0b",
			r.status, r.ext, r.ftype, r.flen, r.has_data, r.data, r.idx, r.last);
	endfunction

	task automatic reset_predictor();
		hdr_word = HEADER_RESET;
		max_len_reg = MAX_LENGTH_RESET;
		rx_phase = SEEK_HI;
		ext_q = '0;
		type_q = '0;
		len_q = '0;
		count_q = '0;
		sum_q = '0;
	endtask

	task automatic add_frame_result(input logic [1:0] st, input logic has,
			input logic [7:0] data, input logic [4:0] idx, input logic fin);
		result_t r;
		int lim;
		lim = length_limit();
		r.status = st;
		r.ext = ext_q;
		r.ftype = type_q;
		r.flen = (len_q > lim) ? 6'(lim) : len_q[5:0];
		r.has_data = has;
		r.data = data;
		r.idx = idx;
		r.last = fin;
		pending_frame_results.push_back(r);
	endtask

	// advance the frame parser by one received byte
	task automatic parse_rx_byte(input logic [7:0] b);
		int i;
		case (rx_phase)
			SEEK_HI: begin
				if (b == hdr_word[15:8]) rx_phase = SEEK_LO;
			end
			SEEK_LO: begin
				if (b == hdr_word[7:0]) begin
					sum_q = hdr_word[15:8] + hdr_word[7:0];
					rx_phase = GET_EXT;
				end else if (b != hdr_word[15:8]) begin
					rx_phase = SEEK_HI;
				end
			end
			GET_EXT: begin
				ext_q = b;
				sum_q += b;
				rx_phase = GET_TYPE;
			end
			GET_TYPE: begin
				type_q = b;
				sum_q += b;
				rx_phase = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				len_q = {b, 8'h00};
				sum_q += b;
				rx_phase = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				len_q[7:0] = b;
				sum_q += b;
				count_q = '0;
				if (len_q > length_limit()) begin
					add_frame_result(STATUS_LEN, 1'b0, 8'h00, 5'd0, 1'b1);
					rx_phase = SEEK_HI;
				end else if (len_q == 0) begin
					rx_phase = GET_CSUM;
				end else begin
					rx_phase = GET_PAYLOAD;
				end
			end
			GET_PAYLOAD: begin
				if (count_q < PAYLOAD_MAX) payload_mem[count_q[4:0]] = b;
				sum_q += b;
				count_q = count_q + 6'd1;
				if (count_q >= len_q) rx_phase = GET_CSUM;
			end
			default: begin
				if (b != sum_q) begin
					add_frame_result(STATUS_CSUM, 1'b0, 8'h00, 5'd0, 1'b1);
				end else if (len_q == 0) begin
					add_frame_result(STATUS_GOOD, 1'b0, 8'h00, 5'd0, 1'b1);
				end else begin
					for (i = 0; i < len_q && i < PAYLOAD_MAX; i++)
						add_frame_result(STATUS_GOOD, 1'b1, payload_mem[i], 5'(i),
							(i + 1 == len_q));
				end
				rx_phase = SEEK_HI;
			end
		endcase
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		bit bad;
		if (pending_frame_results.size() == 0) begin
			errors++;
			if (errors <= REPORT_MAX)
				$display("%0t: unexpected result %s", $time, fmt_result(got));
		end else begin
			want = pending_frame_results.pop_front();
			bad = (got.status !== want.status) || (got.ext !== want.ext) ||
				(got.ftype !== want.ftype) || (got.flen !== want.flen) ||
				(got.has_data !== want.has_data) || (got.data !== want.data) ||
				(got.idx !== want.idx) || (got.last !== want.last);
			if (bad) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: result error, expected %s", $time, fmt_result(want));
					$display("%0t:                 actual %s", $time, fmt_result(got));
				end
			end
		end
	endtask

	// pop side: random stalls, checks every accepted result
	initial begin : result_side
		result_t got;
		int stall;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = stall_on ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			got.status = status;
			got.ext = frame_ext;
			got.ftype = frame_type;
			got.flen = frame_length;
			got.has_data = has_data;
			got.data = data_byte;
			got.idx = byte_index;
			got.last = last;
			check_result(got);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		parse_rx_byte(b);
	endtask

	// builds a frame under the current header; overlong frames stop after the length
	task automatic send_frame(input logic [7:0] ext, input logic [7:0] ftype,
			input logic [15:0] flen, input bit bad_sum, input int keep);
		logic [7:0] sum;
		int i;
		frame_bytes.delete();
		frame_bytes.push_back(hdr_word[15:8]);
		frame_bytes.push_back(hdr_word[7:0]);
		frame_bytes.push_back(ext);
		frame_bytes.push_back(ftype);
		frame_bytes.push_back(flen[15:8]);
		frame_bytes.push_back(flen[7:0]);
		if (flen <= length_limit()) begin
			for (i = 0; i < flen; i++) frame_bytes.push_back(payload_buf[i]);
			sum = '0;
			foreach (frame_bytes[k]) sum += frame_bytes[k];
			if (bad_sum) sum += 8'($urandom_range(1, 255));
			frame_bytes.push_back(sum);
		end
		for (i = 0; i < frame_bytes.size() && i < keep; i++) begin
			send_byte(frame_bytes[i]);
			frame_bytes_sent++;
		end
	endtask

	task automatic drain_idle();
		push <= 1'b0;
		while (pending_frame_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes never toggle it within one step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_HEADER_WORD: hdr_word = val;
			CFG_MAX_LENGTH: max_len_reg = val[5:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] hdr, input logic [5:0] max_len);
		drain_idle();
		write_reg(CFG_HEADER_WORD, hdr);
		write_reg(CFG_MAX_LENGTH, {10'd0, max_len});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_default_frames();
		int i;
		gaps_on = 1'b1;
		stall_on = 1'b1;
		send_frame(8'h00, 8'hFF, 16'd0, 1'b0, WHOLE_FRAME);
		send_frame(8'hFF, 8'h00, 16'd0, 1'b1, WHOLE_FRAME);
		payload_buf[0] = 8'hFF;
		send_frame(8'hFF, 8'h00, 16'd1, 1'b0, WHOLE_FRAME);
		for (i = 0; i < PAYLOAD_MAX; i++) payload_buf[i] = i[0] ? 8'hFF : 8'h00;
		send_frame(8'h5A, 8'hA5, 16'd32, 1'b0, WHOLE_FRAME);
		send_frame(8'h01, 8'h02, 16'd3, 1'b1, WHOLE_FRAME);
		send_frame(8'h10, 8'h20, 16'd33, 1'b0, WHOLE_FRAME);
		send_frame(8'h11, 8'h21, 16'hFFFF, 1'b0, WHOLE_FRAME);
		send_frame(8'h12, 8'h22, 16'h0100, 1'b0, WHOLE_FRAME);
		// repeated first header byte keeps the hunt waiting for the second
		send_byte(hdr_word[15:8]);
		send_frame(8'h33, 8'h44, 16'd2, 1'b0, WHOLE_FRAME);
		// a stray byte between header bytes restarts the hunt
		send_byte(hdr_word[15:8]);
		send_byte(8'h00);
		send_byte(hdr_word[7:0]);
		stall_on = 1'b0;
		gaps_on = 1'b0;
		send_frame(8'h66, 8'h77, 16'd32, 1'b0, WHOLE_FRAME);
		send_frame(8'h88, 8'h99, 16'd32, 1'b0, WHOLE_FRAME);
	endtask

	task automatic test_config_extremes();
		gaps_on = 1'b1;
		stall_on = 1'b1;
		set_config(16'h0000, 6'd0);
		send_frame(8'hC0, 8'h0C, 16'd0, 1'b0, WHOLE_FRAME);
		send_frame(8'hC1, 8'h1C, 16'd1, 1'b0, WHOLE_FRAME);
		set_config(16'hFFFF, 6'd63);
		send_frame(8'hD0, 8'h0D, 16'd32, 1'b0, WHOLE_FRAME);
		send_frame(8'hD1, 8'h1D, 16'd33, 1'b0, WHOLE_FRAME);
		set_config(16'h1234, 6'd1);
		send_frame(8'hE0, 8'h0E, 16'd1, 1'b0, WHOLE_FRAME);
		send_frame(8'hE1, 8'h1E, 16'd2, 1'b0, WHOLE_FRAME);
		// writes to unused indexes must leave both registers alone
		drain_idle();
		write_reg(CFG_SPARE_IDX, 16'h0000);
		write_reg(CFG_TOP_IDX, 16'hBEEF);
		cfg_valid <= 1'b0;
		send_frame(8'hE2, 8'h2E, 16'd1, 1'b0, WHOLE_FRAME);
	endtask

	task automatic test_header_midframe();
		logic [15:0] old_hdr;
		logic [7:0] sum;
		set_config(16'hA5C3, 6'd32);
		old_hdr = hdr_word;
		send_byte(old_hdr[15:8]);
		send_byte(old_hdr[7:0]);
		drain_idle();
		write_reg(CFG_HEADER_WORD, 16'h3C5A);
		cfg_valid <= 1'b0;
		// the rest of the frame still sums against the header it started with
		sum = old_hdr[15:8] + old_hdr[7:0] + 8'h71 + 8'h17 + 8'h00 + 8'h02 + 8'hAB + 8'hCD;
		send_byte(8'h71);
		send_byte(8'h17);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'hAB);
		send_byte(8'hCD);
		send_byte(sum);
		payload_buf[0] = 8'h42;
		send_frame(8'h72, 8'h27, 16'd1, 1'b0, WHOLE_FRAME);
	endtask

	task automatic test_random_traffic();
		int start_count;
		int frames;
		int lim;
		int pick;
		int keep;
		int i;
		logic [15:0] flen;
		logic [5:0] new_max;
		start_count = frame_bytes_sent;
		frames = 0;
		while (frame_bytes_sent - start_count < RANDOM_BYTES) begin
			if (frames % 8 == 0) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) new_max = 6'd0;
				else if (pick == 1) new_max = 6'($urandom_range(33, 63));
				else new_max = 6'($urandom_range(1, 32));
				set_config(16'($urandom), new_max);
			end
			if ($urandom_range(0, 4) == 0) begin
				gaps_on = 1'($urandom_range(0, 1));
				stall_on = 1'($urandom_range(0, 1));
			end
			lim = length_limit();
			pick = $urandom_range(0, 99);
			if (pick < 60) flen = 16'($urandom_range(0, (lim < 8) ? lim : 8));
			else if (pick < 80) flen = 16'($urandom_range(0, lim));
			else if (pick < 90) flen = 16'(lim + $urandom_range(1, 3));
			else flen = 16'($urandom_range(0, 65535));
			for (i = 0; i < PAYLOAD_MAX; i++) payload_buf[i] = 8'($urandom);
			keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 8) : WHOLE_FRAME;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			send_frame(8'($urandom), 8'($urandom), flen, ($urandom_range(0, 6) == 0), keep);
			frames++;
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_predictor();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_frames();
		test_config_extremes();
		test_header_midframe();
		test_random_traffic();
		drain_idle();
		if (errors == 0 && pending_frame_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== serial_frame_receiver_unit.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_ram.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_fifo.sv
hw/rtl/sfr_back.sv
hw/rtl/serial_frame_receiver_unit.sv
tb/serial_frame_receiver_unit_tb.sv
